FILE: rtl/core/starfield_point_projector_defines.svh
// Assertion macros for the starfield point projector.
// Used by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef STARFIELD_POINT_PROJECTOR_DEFINES_SVH
`define STARFIELD_POINT_PROJECTOR_DEFINES_SVH
`ifndef SYNTH
`define SPP_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SPP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define SPP_ASSERT(label, expr, msg)
`define SPP_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/spp_pkg.sv
// Shared types and constants of the starfield point projector.
// No dependencies; every other RTL file refers to it by scoped names.
package spp_pkg;

	// Default table size, output queue depth and pointer width, and divider step counts.
	localparam int STARS_DEF  = 64;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;
	localparam int DIV_STAGES = 10;
	localparam int SIZE_STEPS = 8;

	// Command codes.
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Register indexes and reset values.
	localparam logic [1:0] REG_SPEED  = 2'd0;
	localparam logic [1:0] REG_DMAX   = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;
	localparam logic [15:0] SPEED_RST  = 16'd128;
	localparam logic [7:0]  DMAX_RST   = 8'd5;
	localparam logic [9:0]  WIDTH_RST  = 10'd320;
	localparam logic [9:0]  HEIGHT_RST = 10'd240;

	typedef struct packed {
		logic [15:0] speed;
		logic [7:0]  dmax;
		logic [9:0]  width;
		logic [9:0]  height;
	} cfg_t;

	// One input transaction.
	typedef struct packed {
		logic        cmd;
		logic [5:0]  idx;
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rz;
	} cmd_t;

	// One star table entry: x, y signed with 8 fraction bits, depth Q8.8.
	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic [15:0]        z;
	} star_t;

	// Work handed from the update stages to the divider pipeline.
	typedef struct packed {
		logic        vld;
		logic [25:0] nx;
		logic [25:0] ny;
		logic [15:0] z;
		logic [7:0]  zi;
		logic [7:0]  dmax;
		logic [5:0]  idx;
	} div_in_t;

	// One result square.
	typedef struct packed {
		logic [5:0] star;
		logic [7:0] size;
		logic [9:0] y;
		logic [9:0] x;
	} rect_t;

endpackage

FILE: rtl/core/starfield_point_projector.sv
// Starfield point projector: star table update and perspective projection.
// Holds a table of stars in one memory; each STEP transaction moves a star toward the
// viewer and projects it, emitting one square when the star is on screen.
// Input transactions: s_tuser is the command (0 init, 1 step), s_tdata the star index
// and three random fractions. Output transactions carry the square on m_tdata.
// The user writes registers through cfg_we/cfg_index/cfg_data while the block is idle; the block does not check.
// Throughput: one transaction per cycle while s_tready is high, independent of the star order;
// back-to-back commands on the same star are resolved by forwarding into the read stage.
// Results pass from acceptance through the table update stages and the ten-stage quotient
// pipeline to m_tvalid, plus any time they wait in the output queue.
// s_tready drops while 16 transactions are in flight or queued; a stalled receiver thus
// holds the input back after the queue fills, and nothing is lost.
// Reset clears the queue and the registers to speed 0.5, depth 5, 320 by 240; the
// table has no reset, so the user initialises every star before it is stepped; the block does not check.
`include "starfield_point_projector_defines.svh"
module starfield_point_projector #(
	parameter int STARS = spp_pkg::STARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // star_index[5:0], rand_x[21:6], rand_y[37:22], rand_z[53:38]
	input  logic        s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // rect_x[9:0], rect_y[19:10], rect_size[27:20], drawn_star[33:28]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (STARS > 1) ? $clog2(STARS) : 1;
	localparam int CW = spp_pkg::FIFO_AW + 1;

	spp_pkg::cfg_t    cfg_q;
	spp_pkg::cmd_t    cmd;
	spp_pkg::div_in_t dv;
	spp_pkg::rect_t   rect, head;
	logic             acc, rel, push, pop, not_empty;
	logic [CW-1:0]    credit_q, level;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed  <= spp_pkg::SPEED_RST;
			cfg_q.dmax   <= spp_pkg::DMAX_RST;
			cfg_q.width  <= spp_pkg::WIDTH_RST;
			cfg_q.height <= spp_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				spp_pkg::REG_SPEED:  cfg_q.speed  <= cfg_data;
				spp_pkg::REG_DMAX:   cfg_q.dmax   <= cfg_data[7:0];
				spp_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data[9:0];
				spp_pkg::REG_HEIGHT: cfg_q.height <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Input unpacking.
	assign cmd.cmd = s_tuser;
	assign cmd.idx = s_tdata[5:0];
	assign cmd.rx  = s_tdata[21:6];
	assign cmd.ry  = s_tdata[37:22];
	assign cmd.rz  = s_tdata[53:38];
	assign acc     = s_tvalid && s_tready;

	// Credits: every transaction in flight holds a queue slot until it drops or leaves.
	assign s_tready = credit_q < CW'(spp_pkg::FIFO_DEPTH);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CW'(acc) - CW'(rel) - CW'(pop);
		end
	end

	spp_star_update #(.STARS(STARS), .AW(AW)) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.in_acc (acc),
		.in_cmd (cmd),
		.dv     (dv),
		.rel    (rel)
	);

	spp_div_pipe u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dv     (dv),
		.push   (push),
		.rect   (rect)
	);

	spp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (rect),
		.pop       (pop),
		.not_empty (not_empty),
		.rdata     (head),
		.level     (level)
	);

	// Output packing.
	assign m_tvalid = not_empty;
	assign m_tdata  = {6'h00, head.star, head.size, head.y, head.x};

	`SPP_ASSERT(a_credit_max, credit_q <= CW'(spp_pkg::FIFO_DEPTH), "credit count overrun")
	`SPP_ASSERT(a_level_le_credit, level <= credit_q, "queue holds uncounted results")
	`SPP_ASSERT_IMPLY(a_size_nonzero, m_tvalid, m_tdata[27:20] != 8'h00, "zero square size")

endmodule

FILE: rtl/core/spp_star_ram.sv
// Star table memory: one write port, one read port with registered data.
// Uses spp_pkg for the entry type.
module spp_star_ram #(
	parameter int DEPTH = spp_pkg::STARS_DEF,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  spp_pkg::star_t        wdata,
	input  logic [AW-1:0]         raddr,
	output spp_pkg::star_t        rdata
);

	spp_pkg::star_t mem [0:DEPTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered data, old data on a same-address write.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/spp_star_update.sv
// Read-modify-write of the star table: init, step, respawn and visibility test.
// Depends on spp_pkg and spp_star_ram; forwards in-flight writes to the read stage.
`include "starfield_point_projector_defines.svh"
module spp_star_update #(
	parameter int STARS = spp_pkg::STARS_DEF,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spp_pkg::cfg_t     cfg,
	input  logic              in_acc,
	input  spp_pkg::cmd_t     in_cmd,
	output spp_pkg::div_in_t  dv,
	output logic              rel
);

	// Stage 1 registers.
	logic              acc_s1, vld_s1, cmd_s1;
	logic [AW-1:0]     addr_s1;
	logic [5:0]        idx_s1;
	logic [15:0]       rx_s1, ry_s1, rz_s1;
	// Stage 2 registers.
	logic              acc_s2, vld_s2, cmd_s2;
	logic [AW-1:0]     addr_s2;
	logic [5:0]        idx_s2;
	spp_pkg::star_t    st_s2;
	logic signed [19:0] sx_s2, sy_s2;
	// Last write, for a read that met it at the same edge.
	logic              wvld_q;
	logic [AW-1:0]     waddr_q;
	spp_pkg::star_t    wdata_q;

	spp_pkg::star_t    rdata, resp1, resp2, init1, other, step_o, step_k, nxt, wdata;
	logic signed [19:0] sx1, sy1;
	logic [23:0]       zprod;
	logic              in_range, fwd2, fwdw, off2, res2;
	logic [24:0]       hwz_x, hwz_y;
	logic [25:0]       wz, hz;
	logic signed [27:0] numx, numy;
	logic              offx, offy;

	function automatic logic signed [19:0] spawn(input logic [15:0] r, input logic [9:0] ext);
		logic [26:0] prod;
		prod = r * {ext, 1'b0};
		spawn = $signed({1'b0, prod[26:8]}) - $signed({2'b00, ext, 8'h00});
	endfunction

	function automatic spp_pkg::star_t step(input spp_pkg::star_t s,
		input spp_pkg::star_t resp, input logic [15:0] speed);
		spp_pkg::star_t t;
		t = s;
		if (s.z <= speed) begin
			t = resp;
		end else begin
			t.z = s.z - speed;
		end
		step = t;
	endfunction

	assign in_range = 32'(in_cmd.idx) < STARS;

	spp_star_ram #(.DEPTH(STARS), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (vld_s2),
		.waddr (addr_s2),
		.wdata (wdata),
		.raddr (AW'(in_cmd.idx)),
		.rdata (rdata)
	);

	// Stage 1 capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			acc_s1 <= in_acc;
			vld_s1 <= in_acc && in_range;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= in_cmd.cmd;
		addr_s1 <= AW'(in_cmd.idx);
		idx_s1  <= in_cmd.idx;
		rx_s1   <= in_cmd.rx;
		ry_s1   <= in_cmd.ry;
		rz_s1   <= in_cmd.rz;
	end

	// Stage 1: spawn values, forwarding and the depth step.
	always_comb begin
		sx1   = spawn(rx_s1, cfg.width);
		sy1   = spawn(ry_s1, cfg.height);
		zprod = rz_s1 * cfg.dmax;
		resp1 = '{x: sx1, y: sy1, z: {cfg.dmax, 8'h00}};
		init1 = '{x: sx1, y: sy1, z: zprod[23:8]};
		resp2 = '{x: sx_s2, y: sy_s2, z: {cfg.dmax, 8'h00}};
		fwd2  = vld_s2 && (addr_s2 == addr_s1);
		fwdw  = wvld_q && (waddr_q == addr_s1);
		if (fwd2) begin
			other = resp2;
		end else if (fwdw) begin
			other = wdata_q;
		end else begin
			other = rdata;
		end
		step_o = step(other, resp1, cfg.speed);
		step_k = step(st_s2, resp1, cfg.speed);
		if (cmd_s1 == spp_pkg::CMD_INIT) begin
			nxt = init1;
		end else if (fwd2 && !off2) begin
			nxt = step_k;
		end else begin
			nxt = step_o;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s2 <= 1'b0;
			vld_s2 <= 1'b0;
			wvld_q <= 1'b0;
		end else begin
			acc_s2 <= acc_s1;
			vld_s2 <= vld_s1;
			wvld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2  <= cmd_s1;
		addr_s2 <= addr_s1;
		idx_s2  <= idx_s1;
		st_s2   <= nxt;
		sx_s2   <= sx1;
		sy_s2   <= sy1;
		waddr_q <= addr_s2;
		wdata_q <= wdata;
	end

	// Stage 2: screen test on the numerators W/2*z + x against -z and W*z.
	always_comb begin
		hwz_x = cfg.width[9:1] * st_s2.z;
		hwz_y = cfg.height[9:1] * st_s2.z;
		wz    = cfg.width * st_s2.z;
		hz    = cfg.height * st_s2.z;
		numx  = $signed({3'b000, hwz_x}) + 28'(st_s2.x);
		numy  = $signed({3'b000, hwz_y}) + 28'(st_s2.y);
		offx  = ($signed(numx + $signed({12'h000, st_s2.z})) <= 0)
			|| (numx >= $signed({2'b00, wz}));
		offy  = ($signed(numy + $signed({12'h000, st_s2.z})) <= 0)
			|| (numy >= $signed({2'b00, hz}));
		off2  = (cmd_s2 == spp_pkg::CMD_STEP) && ((st_s2.z == 16'h0000) || offx || offy);
		res2  = vld_s2 && (cmd_s2 == spp_pkg::CMD_STEP) && !off2;
		wdata = off2 ? resp2 : st_s2;
	end

	// Hand-off to the divider; negative numerators above -z truncate to zero.
	always_comb begin
		dv.vld  = res2;
		dv.nx   = numx[27] ? 26'h0 : numx[25:0];
		dv.ny   = numy[27] ? 26'h0 : numy[25:0];
		dv.z    = st_s2.z;
		dv.zi   = (st_s2.z[15:8] == 8'h00) ? 8'h01 : st_s2.z[15:8];
		dv.dmax = cfg.dmax;
		dv.idx  = idx_s2;
		rel     = acc_s2 && !res2;
	end

	`SPP_ASSERT_IMPLY(a_res_nonzero_depth, res2, st_s2.z != 16'h0000, "result with zero depth")
	`SPP_ASSERT_IMPLY(a_vld_is_acc, vld_s2, acc_s2, "table write without a transaction")
	`SPP_ASSERT_IMPLY(a_wr_follows, wvld_q, $past(vld_s2), "write record out of step")

endmodule

FILE: rtl/core/spp_div_pipe.sv
// Pipelined restoring dividers: px, py (10 quotient bits) and square size (8 bits).
// Depends on spp_pkg; one bit of each quotient is resolved per stage.
module spp_div_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  spp_pkg::div_in_t  dv,
	output logic              push,
	output spp_pkg::rect_t    rect
);

	localparam int N = spp_pkg::DIV_STAGES;

	logic        vld_q  [0:N];
	logic [25:0] remx_q [0:N];
	logic [25:0] remy_q [0:N];
	logic [9:0]  qx_q   [0:N];
	logic [9:0]  qy_q   [0:N];
	logic [7:0]  rems_q [0:N];
	logic [7:0]  qs_q   [0:N];
	logic [15:0] z_q    [0:N];
	logic [7:0]  zi_q   [0:N];
	logic [5:0]  idx_q  [0:N];

	logic [7:0]  size, half;

	// Stage 0 load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= dv.vld;
		end
	end

	always_ff @(posedge clk) begin
		remx_q[0] <= dv.nx;
		remy_q[0] <= dv.ny;
		qx_q[0]   <= '0;
		qy_q[0]   <= '0;
		rems_q[0] <= dv.dmax;
		qs_q[0]   <= '0;
		z_q[0]    <= dv.z;
		zi_q[0]   <= dv.zi;
		idx_q[0]  <= dv.idx;
	end

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int B  = N - 1 - j;
		localparam int BS = spp_pkg::SIZE_STEPS - 1 - j;
		logic [25:0] dx;
		logic [15:0] ds;
		logic        bx, by, bs;

		// Trial subtraction of the shifted divisor.
		always_comb begin
			dx = 26'(z_q[j]) << B;
			bx = remx_q[j] >= dx;
			by = remy_q[j] >= dx;
			if (BS >= 0) begin
				ds = 16'(zi_q[j]) << ((BS >= 0) ? BS : 0);
				bs = {8'h00, rems_q[j]} >= ds;
			end else begin
				ds = 16'h0000;
				bs = 1'b0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j+1] <= 1'b0;
			end else begin
				vld_q[j+1] <= vld_q[j];
			end
		end

		always_ff @(posedge clk) begin
			remx_q[j+1] <= bx ? remx_q[j] - dx : remx_q[j];
			remy_q[j+1] <= by ? remy_q[j] - dx : remy_q[j];
			qx_q[j+1]   <= {qx_q[j][8:0], bx};
			qy_q[j+1]   <= {qy_q[j][8:0], by};
			if (BS >= 0) begin
				rems_q[j+1] <= bs ? rems_q[j] - ds[7:0] : rems_q[j];
				qs_q[j+1]   <= {qs_q[j][6:0], bs};
			end else begin
				rems_q[j+1] <= rems_q[j];
				qs_q[j+1]   <= qs_q[j];
			end
			z_q[j+1]   <= z_q[j];
			zi_q[j+1]  <= zi_q[j];
			idx_q[j+1] <= idx_q[j];
		end
	end

	// Size at least one; corner moved up-left by half the size, clamped at zero.
	always_comb begin
		size      = (qs_q[N] == 8'h00) ? 8'h01 : qs_q[N];
		half      = {1'b0, size[7:1]};
		push      = vld_q[N];
		rect.star = idx_q[N];
		rect.size = size;
		rect.x    = (qx_q[N] < 10'(half)) ? 10'h000 : qx_q[N] - 10'(half);
		rect.y    = (qy_q[N] < 10'(half)) ? 10'h000 : qy_q[N] - 10'(half);
	end

endmodule

FILE: rtl/core/spp_out_fifo.sv
// Output queue for result squares, decoupling the divider pipeline from the receiver.
// Depends on spp_pkg for the entry type and depth.
`include "starfield_point_projector_defines.svh"
module spp_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spp_pkg::rect_t  wdata,
	input  logic            pop,
	output logic            not_empty,
	output spp_pkg::rect_t  rdata,
	output logic [spp_pkg::FIFO_AW:0] level
);

	spp_pkg::rect_t mem [0:spp_pkg::FIFO_DEPTH-1];
	logic [spp_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
	logic [spp_pkg::FIFO_AW:0]   cnt_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{spp_pkg::FIFO_AW{1'b0}}, push} - {{spp_pkg::FIFO_AW{1'b0}}, pop};
		end
	end

	assign not_empty = cnt_q != '0;
	assign rdata     = mem[rptr_q];
	assign level     = cnt_q;

	`SPP_ASSERT_IMPLY(a_no_overflow, push && !pop,
		cnt_q < (spp_pkg::FIFO_AW+1)'(spp_pkg::FIFO_DEPTH), "output queue overflow")

endmodule

FILE: bench/starfield_point_projector_test.sv
// Self-checking bench for the starfield point projector: directed table, then random traffic.
// Depends on spp_pkg and the starfield_point_projector RTL; a local predictor mirrors the table.
`timescale 1ns / 1ps
module starfield_point_projector_test;

	localparam int NSTAR = 64;
	localparam int SETTLE = 40;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct {
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] size;
		logic [5:0] star;
	} square_t;

	typedef struct {
		logic        cmd;
		logic [5:0]  idx;
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rz;
		bit          typed;
		square_t     sq;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;  // star_index, rand_x, rand_y, rand_z
	logic        s_tuser = 1'b0; // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // rect_x, rect_y, rect_size, drawn_star
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predictor copy of registers and star table.
	logic [15:0] p_speed;
	logic [7:0]  p_dmax;
	logic [9:0]  p_width;
	logic [9:0]  p_height;
	logic signed [19:0] tab_x[NSTAR];
	logic signed [19:0] tab_y[NSTAR];
	logic [15:0]        tab_z[NSTAR];
	bit                 star_ready[NSTAR];

	square_t pending_squares[$];
	int      errors = 0;
	int      squares_seen = 0;
	int      items_sent = 0;
	int      tx_idle_pct = 0;
	int      rx_idle_pct = 0;
	int      rx_hold = 0;
	longint  cycles = 0;

	starfield_point_projector dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL starfield_point_projector");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic logic signed [19:0] spawn_pos(input logic [15:0] r, input logic [9:0] ext);
		longint span;
		span = (longint'(r) * 2 * longint'(ext)) >>> 8;
		return 20'(span - longint'(ext) * 256);
	endfunction

	function automatic longint proj(input logic signed [19:0] pos, input logic [9:0] ext,
			input logic [15:0] z);
		longint num;
		num = longint'(ext / 2) * longint'(z) + longint'(pos);
		return num / longint'(z);
	endfunction

	function automatic void place_star(input int k, input logic [15:0] rx, input logic [15:0] ry);
		tab_x[k] = spawn_pos(rx, p_width);
		tab_y[k] = spawn_pos(ry, p_height);
		tab_z[k] = {p_dmax, 8'h00};
	endfunction

	// Advances the table for one command; returns 1 with the square when one is drawn.
	function automatic bit predict_square(input logic cmd, input logic [5:0] k,
			input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] rz,
			output square_t sq);
		longint px, py, ex, ey;
		int zint, sz;
		sq = '{default: '0};
		if (cmd == spp_pkg::CMD_INIT) begin
			place_star(k, rx, ry);
			tab_z[k] = 16'((32'(rz) * 32'(p_dmax)) >> 8);
			star_ready[k] = 1'b1;
			return 1'b0;
		end
		if (tab_z[k] <= p_speed)
			place_star(k, rx, ry);
		else
			tab_z[k] = tab_z[k] - p_speed;
		if (tab_z[k] == 0) begin
			place_star(k, rx, ry);
			return 1'b0;
		end
		px = proj(tab_x[k], p_width, tab_z[k]);
		py = proj(tab_y[k], p_height, tab_z[k]);
		if (px < 0 || py < 0 || px >= p_width || py >= p_height) begin
			place_star(k, rx, ry);
			return 1'b0;
		end
		zint = tab_z[k] >> 8;
		if (zint < 1)
			zint = 1;
		sz = p_dmax / zint;
		if (sz < 1)
			sz = 1;
		ex = px - sz / 2;
		ey = py - sz / 2;
		if (ex < 0)
			ex = 0;
		if (ey < 0)
			ey = 0;
		sq.x = 10'(ex);
		sq.y = 10'(ey);
		sq.size = 8'(sz);
		sq.star = k;
		return 1'b1;
	endfunction

	// Offers one transaction with random gaps and records what it should produce.
	task automatic send_item(input row_t r);
		square_t sq;
		bit drawn;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {2'b00, r.rz, r.ry, r.rx, r.idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		drawn = predict_square(r.cmd, r.idx, r.rx, r.ry, r.rz, sq);
		if (r.typed) begin
			pending_squares.push_back(r.sq);
			if (!drawn)
				report("directed row expects a square the predictor does not draw");
		end else if (drawn) begin
			pending_squares.push_back(sq);
		end
	endtask

	// Drains all expected squares, then lets in-flight inits finish.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_squares.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			spp_pkg::REG_SPEED:  p_speed = val;
			spp_pkg::REG_DMAX:   p_dmax = val[7:0];
			spp_pkg::REG_WIDTH:  p_width = val[9:0];
			default:             p_height = val[9:0];
		endcase
	endtask

	// Receiver: random back-pressure plus an optional long hold-off.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare every output transaction with the oldest expected square.
	always @(posedge clk) begin
		square_t want;
		if (arst_n && m_tvalid && m_tready) begin
			squares_seen++;
			if (pending_squares.size() == 0) begin
				report($sformatf("unexpected square %h", m_tdata));
			end else begin
				want = pending_squares.pop_front();
				if (m_tdata[9:0] != want.x)
					report($sformatf("rect_x %0d, want %0d", m_tdata[9:0], want.x));
				if (m_tdata[19:10] != want.y)
					report($sformatf("rect_y %0d, want %0d", m_tdata[19:10], want.y));
				if (m_tdata[27:20] != want.size)
					report($sformatf("rect_size %0d, want %0d", m_tdata[27:20], want.size));
				if (m_tdata[33:28] != want.star)
					report($sformatf("drawn_star %0d, want %0d", m_tdata[33:28], want.star));
			end
		end
	end

	initial begin
		row_t dir[$];
		row_t r;
		int per_phase;
		p_speed = spp_pkg::SPEED_RST;
		p_dmax = spp_pkg::DMAX_RST;
		p_width = spp_pkg::WIDTH_RST;
		p_height = spp_pkg::HEIGHT_RST;
		foreach (star_ready[i])
			star_ready[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under reset settings. A centered star at zero depth respawns and
		// lands on the screen center as a one-pixel square.
		dir.push_back('{spp_pkg::CMD_INIT, 6'd0, 16'h8000, 16'h8000, 16'h0000, 0,
			'{default: '0}});
		dir.push_back('{spp_pkg::CMD_STEP, 6'd0, 16'h8000, 16'h8000, 16'h0000, 1,
			'{10'd160, 10'd120, 8'd1, 6'd0}});
		dir.push_back('{spp_pkg::CMD_INIT, 6'd1, 16'h0000, 16'h0000, 16'hFFFF, 0,
			'{default: '0}});
		dir.push_back('{spp_pkg::CMD_INIT, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0,
			'{default: '0}});
		dir.push_back('{spp_pkg::CMD_INIT, 6'd2, 16'hFFFF, 16'h0000, 16'h8000, 0,
			'{default: '0}});
		// Edge stars drift outward until they leave the screen and respawn.
		for (int i = 0; i < 8; i++) begin
			dir.push_back('{spp_pkg::CMD_STEP, 6'd1, 16'h1234, 16'hFEDC, 16'hFFFF, 0,
				'{default: '0}});
			dir.push_back('{spp_pkg::CMD_STEP, 6'd63, 16'hFFFF, 16'h0000, 16'h0000, 0,
				'{default: '0}});
		end
		dir.push_back('{spp_pkg::CMD_STEP, 6'd2, 16'h0000, 16'hFFFF, 16'h5555, 0,
			'{default: '0}});
		dir.push_back('{spp_pkg::CMD_STEP, 6'd0, 16'hAAAA, 16'h5555, 16'hFFFF, 0,
			'{default: '0}});
		tx_idle_pct = 24;
		rx_idle_pct = 56;
		foreach (dir[i])
			send_item(dir[i]);
		wait_idle();

		// Bring every star into the table.
		for (int k = 0; k < NSTAR; k++) begin
			r = '{spp_pkg::CMD_INIT, 6'(k), 16'($urandom), 16'($urandom), 16'($urandom), 0,
				'{default: '0}};
			send_item(r);
		end
		wait_idle();

		// Random phases, each under its own register setting.
		per_phase = 230;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				write_reg(spp_pkg::REG_SPEED, 16'd0);
				write_reg(spp_pkg::REG_DMAX, 16'd255);
				write_reg(spp_pkg::REG_WIDTH, 16'd1023);
				write_reg(spp_pkg::REG_HEIGHT, 16'd1023);
			end else if (ph == 1) begin
				write_reg(spp_pkg::REG_SPEED, 16'hFFFF);
				write_reg(spp_pkg::REG_DMAX, 16'd1);
				write_reg(spp_pkg::REG_WIDTH, 16'd16);
				write_reg(spp_pkg::REG_HEIGHT, 16'd16);
			end else begin
				write_reg(spp_pkg::REG_SPEED, ($urandom_range(3) == 0) ? 16'($urandom)
					: 16'($urandom_range(1023)));
				write_reg(spp_pkg::REG_DMAX, 16'($urandom_range(255, 1)));
				write_reg(spp_pkg::REG_WIDTH, 16'($urandom_range(1023, 16)));
				write_reg(spp_pkg::REG_HEIGHT, 16'($urandom_range(1023, 16)));
			end
			if (ph < 3) begin
				tx_idle_pct = 24;
				rx_idle_pct = 56;
			end else if (ph < 6) begin
				tx_idle_pct = 56;
				rx_idle_pct = 24;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int n = 0; n < per_phase; n++) begin
				// A long receiver hold-off while the sender keeps offering.
				if (ph == 6 && n == 20)
					rx_hold = 400;
				r.cmd = ($urandom_range(9) == 0) ? spp_pkg::CMD_INIT : spp_pkg::CMD_STEP;
				r.idx = 6'($urandom_range(NSTAR - 1));
				r.rx = 16'($urandom);
				r.ry = 16'($urandom);
				r.rz = 16'($urandom);
				r.typed = 0;
				r.sq = '{default: '0};
				send_item(r);
			end
			wait_idle();
		end

		$display("covered %0d transactions and %0d squares over 9 register settings",
			items_sent, squares_seen);
		$display("including extreme speeds, depths and screen sizes, and a long output stall");
		if (errors == 0)
			$display("PASS starfield_point_projector");
		else
			$display("FAIL starfield_point_projector");
		$finish;
	end

endmodule
